FILE: hw/rtl/scl_pkg.sv
// shared types and constants for the sensor command line parser
package scl_pkg;

	localparam int unsigned PFX_COUNT = 7;
	localparam int unsigned PFX_CHARS = 8;
	localparam logic [2:0]  NUM_START = 3'd7;
	localparam logic [6:0]  PFX_ALL   = 7'h7F;
	localparam logic [7:0]  CH_NL     = 8'd10;
	localparam logic [7:0]  CH_NUL    = 8'd0;
	localparam logic [7:0]  CH_SPACE  = 8'd32;
	localparam logic [7:0]  CH_TAB    = 8'd9;
	localparam logic [7:0]  CH_CR     = 8'd13;
	localparam logic [7:0]  CH_PLUS   = "+";
	localparam logic [7:0]  CH_MINUS  = "-";
	localparam logic [7:0]  CH_ZERO   = "0";
	localparam logic [7:0]  CH_NINE   = "9";

	localparam logic [31:0] MAG_LIMIT = 32'h8000_0000;
	localparam logic [31:0] POS_MAX   = 32'h7FFF_FFFF;

	// configuration register indexes
	localparam logic REG_INITIAL_CELSIUS = 1'b0;
	localparam logic REG_INITIAL_PERIOD  = 1'b1;

	typedef enum logic [2:0] {
		CMD_NONE    = 3'd0,
		CMD_SCALE_F = 3'd1,
		CMD_SCALE_C = 3'd2,
		CMD_STOP    = 3'd3,
		CMD_START   = 3'd4,
		CMD_OFF     = 3'd5,
		CMD_PERIOD  = 3'd6,
		CMD_LOG     = 3'd7
	} cmd_t;

	typedef enum logic [2:0] {
		PH_BLANK  = 3'b001,
		PH_DIGITS = 3'b010,
		PH_DONE   = 3'b100
	} num_phase_t;

	typedef struct packed {
		num_phase_t  phase;
		logic        negative;
		logic [31:0] value;
	} num_state_t;

	localparam logic [7:0] PFX_TEXT [PFX_COUNT][PFX_CHARS] = '{
		'{"S", "C", "A", "L", "E", "=", "F", 8'h00},
		'{"S", "C", "A", "L", "E", "=", "C", 8'h00},
		'{"S", "T", "O", "P", 8'h00, 8'h00, 8'h00, 8'h00},
		'{"S", "T", "A", "R", "T", 8'h00, 8'h00, 8'h00},
		'{"O", "F", "F", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
		'{"P", "E", "R", "I", "O", "D", "=", 8'h00},
		'{"L", "O", "G", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}
	};

	localparam logic [2:0] PFX_LEN [PFX_COUNT] = '{
		3'd7, 3'd7, 3'd4, 3'd5, 3'd3, 3'd7, 3'd3
	};

	localparam cmd_t PFX_CMD [PFX_COUNT] = '{
		CMD_SCALE_F, CMD_SCALE_C, CMD_STOP, CMD_START, CMD_OFF, CMD_PERIOD, CMD_LOG
	};

endpackage

FILE: hw/rtl/scl_prefix_match.sv
// prefix match mask update and command pick at end of line
module scl_prefix_match (
	input  logic [7:0]  rx_char,
	input  logic [2:0]  pos,
	input  logic        pos_big,
	input  logic [6:0]  mask,
	output logic [6:0]  mask_next,
	output scl_pkg::cmd_t cmd
);

	always_comb begin
		mask_next = mask;
		for (int i = 0; i < scl_pkg::PFX_COUNT; i++) begin
			if (!pos_big && pos < scl_pkg::PFX_LEN[i]
					&& rx_char != scl_pkg::PFX_TEXT[i][pos])
				mask_next[i] = 1'b0;
		end
	end

	// first prefix in list order wins
	always_comb begin
		cmd = scl_pkg::CMD_NONE;
		for (int i = scl_pkg::PFX_COUNT - 1; i >= 0; i--) begin
			if (mask[i] && (pos_big || pos >= scl_pkg::PFX_LEN[i]))
				cmd = scl_pkg::PFX_CMD[i];
		end
	end

endmodule

FILE: hw/rtl/scl_number.sv
// atoi-style decimal scanner step and saturated result
module scl_number (
	input  logic [7:0]          rx_char,
	input  scl_pkg::num_state_t cur,
	output scl_pkg::num_state_t nxt,
	output logic [31:0]         result
);

	logic        is_blank;
	logic        is_digit;
	logic        is_sign;
	logic [35:0] acc;
	logic [31:0] acc_sat;

	assign is_blank = (rx_char == scl_pkg::CH_SPACE)
		|| (rx_char >= scl_pkg::CH_TAB && rx_char <= scl_pkg::CH_CR);
	assign is_digit = (rx_char >= scl_pkg::CH_ZERO) && (rx_char <= scl_pkg::CH_NINE);
	assign is_sign  = (rx_char == scl_pkg::CH_PLUS) || (rx_char == scl_pkg::CH_MINUS);

	// value * 10 + digit, clamped to the magnitude of the most negative value
	assign acc = ({4'b0, cur.value} << 3) + ({4'b0, cur.value} << 1)
		+ {32'b0, rx_char[3:0]};
	assign acc_sat = (acc > {4'b0, scl_pkg::MAG_LIMIT}) ? scl_pkg::MAG_LIMIT : acc[31:0];

	always_comb begin
		nxt = cur;
		case (cur.phase)
			scl_pkg::PH_BLANK: begin
				if (is_blank) begin
					nxt.phase = scl_pkg::PH_BLANK;
				end else if (is_sign) begin
					nxt.phase    = scl_pkg::PH_DIGITS;
					nxt.negative = (rx_char == scl_pkg::CH_MINUS);
				end else if (is_digit) begin
					nxt.phase = scl_pkg::PH_DIGITS;
					nxt.value = acc_sat;
				end else begin
					nxt.phase = scl_pkg::PH_DONE;
				end
			end
			scl_pkg::PH_DIGITS: begin
				if (is_digit)
					nxt.value = acc_sat;
				else
					nxt.phase = scl_pkg::PH_DONE;
			end
			scl_pkg::PH_DONE: begin
				nxt.phase = scl_pkg::PH_DONE;
			end
			default: begin
				nxt.phase = scl_pkg::PH_DONE;
			end
		endcase
	end

	always_comb begin
		if (cur.negative)
			result = 32'd0 - cur.value;
		else if (cur.value[31])
			result = scl_pkg::POS_MAX;
		else
			result = cur.value;
	end

endmodule

FILE: hw/rtl/sensor_command_line_parser_top.sv
// sensor command line parser top level: input stage, line state and result register
// an accepted byte goes through the input stage, then the result register, which holds its result transaction
// throughput: one byte per cycle unless the receiver stalls; each byte needs one prefix compare
// and one multiply by ten in the single parse stage between the input register and the result register
// reset: scale Fahrenheit, not stopped, period 1, line state cleared, both pipes empty
// a configuration write loads the live scale or period directly
module sensor_command_line_parser_top #(
	parameter int unsigned LINE_MAX = 256
) (
	input  logic               clk,
	input  logic               arst_n,
	// command byte channel
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [7:0]         rx_byte,
	// result channel
	output logic               out_valid,
	input  logic               out_stall,
	output logic               line_done,
	output logic [2:0]         command,
	output logic               scale_celsius,
	output logic               stopped,
	output logic signed [31:0] report_period,
	output logic               shutdown,
	// configuration write port
	input  logic               wr_en,
	input  logic               wr_index,
	input  logic [31:0]        wr_data
);

	localparam int unsigned CNT_W = $clog2(LINE_MAX + 1);

	// input stage
	logic       valid_s1;
	logic [7:0] byte_s1;

	// line state
	logic [CNT_W-1:0]    char_count_q;
	logic [6:0]          match_mask_q;
	logic                text_ended_q;
	scl_pkg::num_state_t num_q;

	// live settings
	logic        scale_q;
	logic        stop_q;
	logic [31:0] period_q;

	// result register
	logic          out_valid_q;
	logic          line_done_q;
	scl_pkg::cmd_t command_q;
	logic          shutdown_q;

	logic                advance;
	logic                fire;
	logic                is_nl;
	logic                take_char;
	logic                pos_big;
	logic                in_number;
	logic [6:0]          mask_next;
	scl_pkg::cmd_t       line_cmd;
	scl_pkg::num_state_t num_next;
	logic [31:0]         num_result;

	// result register frees up when empty or being taken this cycle
	assign advance  = !out_valid_q || !out_stall;
	assign fire     = valid_s1 && advance;
	assign in_stall = valid_s1 && !advance;

	assign is_nl     = (byte_s1 == scl_pkg::CH_NL);
	// bytes past the line limit or after a zero byte are dropped until newline
	assign take_char = !is_nl && !text_ended_q && (char_count_q < CNT_W'(LINE_MAX));
	assign pos_big   = |char_count_q[CNT_W-1:3];
	assign in_number = pos_big || (char_count_q[2:0] == scl_pkg::NUM_START);

	scl_prefix_match u_match (
		.rx_char   (byte_s1),
		.pos       (char_count_q[2:0]),
		.pos_big   (pos_big),
		.mask      (match_mask_q),
		.mask_next (mask_next),
		.cmd       (line_cmd)
	);

	scl_number u_number (
		.rx_char (byte_s1),
		.cur     (num_q),
		.nxt     (num_next),
		.result  (num_result)
	);

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!valid_s1 || advance) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall)
			byte_s1 <= rx_byte;
	end

	// line state and settings, updated as each byte goes into the result register; settings also on a configuration write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			char_count_q <= '0;
			match_mask_q <= scl_pkg::PFX_ALL;
			text_ended_q <= 1'b0;
			num_q        <= '{phase: scl_pkg::PH_BLANK, negative: 1'b0, value: 32'd0};
			scale_q      <= 1'b0;
			stop_q       <= 1'b0;
			period_q     <= 32'd1;
		end else begin
			if (fire && is_nl) begin
				case (line_cmd)
					scl_pkg::CMD_SCALE_F: scale_q  <= 1'b0;
					scl_pkg::CMD_SCALE_C: scale_q  <= 1'b1;
					scl_pkg::CMD_STOP:    stop_q   <= 1'b1;
					scl_pkg::CMD_START:   stop_q   <= 1'b0;
					scl_pkg::CMD_PERIOD:  period_q <= num_result;
					default: ;
				endcase
				char_count_q <= '0;
				match_mask_q <= scl_pkg::PFX_ALL;
				text_ended_q <= 1'b0;
				num_q        <= '{phase: scl_pkg::PH_BLANK, negative: 1'b0, value: 32'd0};
			end else if (fire && take_char) begin
				if (byte_s1 == scl_pkg::CH_NUL) begin
					text_ended_q <= 1'b1;
				end else begin
					match_mask_q <= mask_next;
					if (in_number)
						num_q <= num_next;
					char_count_q <= char_count_q + 1'b1;
				end
			end
			// configuration is to be written by the user only while idle; the block itself does not enforce it
			if (wr_en) begin
				case (wr_index)
					scl_pkg::REG_INITIAL_CELSIUS: scale_q  <= wr_data[0];
					scl_pkg::REG_INITIAL_PERIOD:  period_q <= wr_data;
					default: ;
				endcase
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			line_done_q <= is_nl;
			command_q   <= is_nl ? line_cmd : scl_pkg::CMD_NONE;
			shutdown_q  <= is_nl && (line_cmd == scl_pkg::CMD_OFF);
		end
	end

	assign out_valid     = out_valid_q;
	assign line_done     = line_done_q;
	assign command       = command_q;
	assign shutdown      = shutdown_q;
	// live settings stay in step with the held result: the input stage stalls with it
	assign scale_celsius = scale_q;
	assign stopped       = stop_q;
	assign report_period = period_q;

	// checks

	// shutdown only on a completed off line
	a_shutdown_off: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && shutdown_q |-> line_done_q && command_q == scl_pkg::CMD_OFF)
		else $error("shutdown without off line");

	// a command is only reported with the newline
	a_cmd_on_nl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && command_q != scl_pkg::CMD_NONE |-> line_done_q)
		else $error("command on a byte that is not newline");

	// newline clears the line state
	a_line_clear: assert property (@(posedge clk) disable iff (!arst_n)
		fire && is_nl && !wr_en |=> char_count_q == '0 && match_mask_q == scl_pkg::PFX_ALL
			&& !text_ended_q)
		else $error("line state not cleared after newline");

	// character count never passes the line limit
	a_count_limit: assert property (@(posedge clk) disable iff (!arst_n)
		char_count_q <= CNT_W'(LINE_MAX))
		else $error("character count beyond line limit");

endmodule

FILE: test/testbench.sv
// self-checking testbench for the sensor command line parser top level
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned LINE_MAX       = 256;
	localparam int          RESULT_LATENCY = 2;       // input stage plus result register
	localparam int          CYCLE_LIMIT    = 400000;  // far beyond the slowest correct run
	localparam int          PHASE_BYTES    = 265;     // random command bytes per idle mix
	localparam int          HOLD_CYCLES    = 300;     // long receiver hold-off

	// blanks that the number parser skips: space, tab, vertical tab, form feed, carriage return
	localparam logic [7:0] BLANK_BYTES [5] = '{8'd32, 8'd9, 8'd11, 8'd12, 8'd13};

	// one result transaction as seen on the output channel
	typedef struct packed {
		logic               line_done;
		scl_pkg::cmd_t      command;
		logic               scale_celsius;
		logic               stopped;
		logic signed [31:0] report_period;
		logic               shutdown;
	} parse_result_t;

	// where the period number is in its parse
	typedef enum logic [1:0] {
		SKIP_BLANKS,
		READ_DIGITS,
		NUMBER_DONE
	} digit_phase_t;

	// one directed line: head text, a run of fill bytes, tail text, then the newline;
	// where typed is set the newline result is written out by hand
	typedef struct {
		string         head;
		int            fill_n;
		logic [7:0]    fill_b;
		string         tail;
		bit            typed;
		scl_pkg::cmd_t cmd;
		logic          celsius;
		logic          halted;
		logic [31:0]   period;
		logic          off;
	} line_case_t;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_stall;
	logic [7:0]         rx_byte;
	logic               out_valid;
	logic               out_stall;
	logic               line_done;
	logic [2:0]         command;
	logic               scale_celsius;
	logic               stopped;
	logic signed [31:0] report_period;
	logic               shutdown;
	logic               wr_en;
	logic               wr_index;
	logic [31:0]        wr_data;

	// prefixes in priority order; entry k gives command k + 1
	string prefix_word [7] = '{"SCALE=F", "SCALE=C", "STOP", "START", "OFF", "PERIOD=", "LOG"};

	// directed lines, run right after reset with the reset register values
	line_case_t directed_lines [24] = '{
		'{"",                    0,   8'h00, "",    1'b1,
			scl_pkg::CMD_NONE,    1'b0, 1'b0, 32'd1, 1'b0},
		'{"SCALE=C",             0,   8'h00, "",    1'b1,
			scl_pkg::CMD_SCALE_C, 1'b1, 1'b0, 32'd1, 1'b0},
		'{"STOP",                0,   8'h00, "",    1'b1,
			scl_pkg::CMD_STOP,    1'b1, 1'b1, 32'd1, 1'b0},
		'{"LOG extra",           0,   8'h00, "",    1'b1,
			scl_pkg::CMD_LOG,     1'b1, 1'b1, 32'd1, 1'b0},
		'{"OFF",                 0,   8'h00, "",    1'b1,
			scl_pkg::CMD_OFF,     1'b1, 1'b1, 32'd1, 1'b1},
		'{"START",               0,   8'h00, "",    1'b1,
			scl_pkg::CMD_START,   1'b1, 1'b0, 32'd1, 1'b0},
		'{"PERIOD=2147483647",   0,   8'h00, "",    1'b1,
			scl_pkg::CMD_PERIOD,  1'b1, 1'b0, 32'h7FFF_FFFF, 1'b0},
		'{"PERIOD=-2147483648",  0,   8'h00, "",    1'b1,
			scl_pkg::CMD_PERIOD,  1'b1, 1'b0, 32'h8000_0000, 1'b0},
		'{"PERIOD=99999999999",  0,   8'h00, "",    1'b1,
			scl_pkg::CMD_PERIOD,  1'b1, 1'b0, 32'h7FFF_FFFF, 1'b0},
		'{"PERIOD=-99999999999", 0,   8'h00, "",    1'b1,
			scl_pkg::CMD_PERIOD,  1'b1, 1'b0, 32'h8000_0000, 1'b0},
		'{"PERIOD=  +12x3",      0,   8'h00, "",    1'b1,
			scl_pkg::CMD_PERIOD,  1'b1, 1'b0, 32'd12, 1'b0},
		'{"PERIOD=\t-7",         0,   8'h00, "",    1'b1,
			scl_pkg::CMD_PERIOD,  1'b1, 1'b0, 32'hFFFF_FFF9, 1'b0},
		'{"PERIOD=",             0,   8'h00, "",    1'b1,
			scl_pkg::CMD_PERIOD,  1'b1, 1'b0, 32'd0, 1'b0},
		'{"SCALE=F",             0,   8'h00, "",    1'b1,
			scl_pkg::CMD_SCALE_F, 1'b0, 1'b0, 32'd0, 1'b0},
		// zero byte cuts the text before the prefix is complete
		'{"STO",                 1,   8'h00, "P",   1'b1,
			scl_pkg::CMD_NONE,    1'b0, 1'b0, 32'd0, 1'b0},
		'{"SCALE",               2,   8'hFF, "",    1'b0,
			scl_pkg::CMD_NONE,    1'b0, 1'b0, 32'd0, 1'b0},
		// long line: the digit at the last stored position counts, the rest is dropped
		'{"PERIOD=",             248, 8'h20, "542", 1'b1,
			scl_pkg::CMD_PERIOD,  1'b0, 1'b0, 32'd5, 1'b0},
		'{"stop",                0,   8'h00, "",    1'b0,
			scl_pkg::CMD_NONE,    1'b0, 1'b0, 32'd0, 1'b0},
		'{"STAR",                0,   8'h00, "",    1'b0,
			scl_pkg::CMD_NONE,    1'b0, 1'b0, 32'd0, 1'b0},
		'{"SCALE=Fahrenheit",    0,   8'h00, "",    1'b0,
			scl_pkg::CMD_NONE,    1'b0, 1'b0, 32'd0, 1'b0},
		'{"OFFSTOP",             0,   8'h00, "",    1'b0,
			scl_pkg::CMD_NONE,    1'b0, 1'b0, 32'd0, 1'b0},
		'{"",                    300, 8'h41, "",    1'b0,
			scl_pkg::CMD_NONE,    1'b0, 1'b0, 32'd0, 1'b0},
		'{"PERIOD=-0",           0,   8'h00, "",    1'b0,
			scl_pkg::CMD_NONE,    1'b0, 1'b0, 32'd0, 1'b0},
		'{"PERIOD=+",            1,   8'h00, "9",   1'b0,
			scl_pkg::CMD_NONE,    1'b0, 1'b0, 32'd0, 1'b0}
	};

	// predictor state, a private copy of what the block keeps
	int unsigned  seen_chars;
	logic [6:0]   live_mask;
	bit           text_cut;
	digit_phase_t num_phase;
	bit           num_neg;
	logic [31:0]  num_mag;
	logic         celsius_now;
	logic         halted_now;
	logic [31:0]  period_now;

	parse_result_t pending_results [$];

	int mismatch_count;
	int bytes_sent;
	int lines_seen;
	int period_loads;
	int off_lines;
	int cycle_count;
	int idle_pct;      // sender idle chance per cycle, in percent
	int stall_pct;     // receiver stall chance per cycle, in percent
	int hold_request;  // long hold-off asked by the stimulus process
	int hold_left;     // owned by the receiver process

	sensor_command_line_parser_top #(
		.LINE_MAX(LINE_MAX)
	) u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.rx_byte      (rx_byte),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.line_done    (line_done),
		.command      (command),
		.scale_celsius(scale_celsius),
		.stopped      (stopped),
		.report_period(report_period),
		.shutdown     (shutdown),
		.wr_en        (wr_en),
		.wr_index     (wr_index),
		.wr_data      (wr_data)
	);

	// clock, 12 ns period
	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// clear the per-line parse state
	function automatic void clear_line();
		seen_chars = 0;
		live_mask  = 7'h7F;
		text_cut   = 1'b0;
		num_phase  = SKIP_BLANKS;
		num_neg    = 1'b0;
		num_mag    = 32'd0;
	endfunction

	// atoi-style digit accumulation, magnitude clamps at 2^31
	function automatic void feed_period_digit(input logic [7:0] b);
		logic [63:0] m;
		if (num_phase == SKIP_BLANKS) begin
			if (b == 8'd32 || (b >= 8'd9 && b <= 8'd13))
				return;
			num_phase = READ_DIGITS;
			if (b == "+" || b == "-") begin
				num_neg = (b == "-");
				return;
			end
		end
		if (num_phase == READ_DIGITS) begin
			if (b >= "0" && b <= "9") begin
				m = 64'(num_mag) * 64'd10 + 64'(b - 8'd48);
				if (m > 64'h8000_0000)
					m = 64'h8000_0000;
				num_mag = m[31:0];
			end else begin
				num_phase = NUMBER_DONE;
			end
		end
	endfunction

	function automatic logic [31:0] period_from_text();
		if (num_neg)
			return 32'd0 - num_mag;
		if (num_mag > 32'h7FFF_FFFF)
			return 32'h7FFF_FFFF;
		return num_mag;
	endfunction

	// advance the private parse state by one byte and give the result it causes
	function automatic parse_result_t parse_byte(input logic [7:0] b);
		parse_result_t r;
		scl_pkg::cmd_t hit;
		r   = '0;
		hit = scl_pkg::CMD_NONE;
		if (b == 8'd10) begin
			r.line_done = 1'b1;
			lines_seen++;
			for (int k = 0; k < 7; k++)
				if (hit == scl_pkg::CMD_NONE && live_mask[k]
						&& seen_chars >= prefix_word[k].len())
					hit = scl_pkg::cmd_t'(k + 1);
			case (hit)
				scl_pkg::CMD_SCALE_F: celsius_now = 1'b0;
				scl_pkg::CMD_SCALE_C: celsius_now = 1'b1;
				scl_pkg::CMD_STOP:    halted_now  = 1'b1;
				scl_pkg::CMD_START:   halted_now  = 1'b0;
				scl_pkg::CMD_OFF: begin
					r.shutdown = 1'b1;
					off_lines++;
				end
				scl_pkg::CMD_PERIOD: begin
					period_now = period_from_text();
					period_loads++;
				end
				default: ;
			endcase
			clear_line();
		end else if (!text_cut && seen_chars < LINE_MAX) begin
			if (b == 8'd0) begin
				text_cut = 1'b1;
			end else begin
				for (int k = 0; k < 7; k++)
					if (seen_chars < prefix_word[k].len() && b != prefix_word[k][seen_chars])
						live_mask[k] = 1'b0;
				if (seen_chars >= 7)
					feed_period_digit(b);
				seen_chars++;
			end
		end
		r.command       = hit;
		r.scale_celsius = celsius_now;
		r.stopped       = halted_now;
		r.report_period = period_now;
		return r;
	endfunction

	function automatic void push_text(ref logic [7:0] q[$], input string s);
		for (int j = 0; j < s.len(); j++)
			q.push_back(s[j]);
	endfunction

	// random line text without its newline: mostly real commands with random
	// content, then near misses, zero bytes, raw noise and the odd long line
	function automatic void build_line(ref logic [7:0] q[$]);
		int    pick;
		int    k;
		int    cut;
		int    n;
		string word;
		q.delete();
		pick = $urandom_range(99);
		k    = $urandom_range(6);
		word = prefix_word[k];
		if (pick < 55) begin
			push_text(q, word);
			if (k == 5) begin
				repeat ($urandom_range(2)) q.push_back(BLANK_BYTES[$urandom_range(4)]);
				case ($urandom_range(2))
					1:       q.push_back("+");
					2:       q.push_back("-");
					default: ;
				endcase
				// about a third of the numbers get ten to twelve digits, mostly long enough to saturate
				n = ($urandom_range(2) == 0) ? $urandom_range(12, 10) : $urandom_range(9);
				repeat (n) q.push_back(8'd48 + 8'($urandom_range(9)));
				if ($urandom_range(3) == 0)
					q.push_back(8'($urandom_range(126, 32)));
			end else begin
				repeat ($urandom_range(3)) q.push_back(8'($urandom_range(126, 32)));
			end
		end else if (pick < 70) begin
			// cut short, or one letter with its case flipped
			cut = $urandom_range(word.len() - 1);
			for (int j = 0; j < cut; j++)
				q.push_back(word[j]);
			if ($urandom_range(1)) begin
				q.push_back(word[cut] ^ 8'h20);
				for (int j = cut + 1; j < word.len(); j++)
					q.push_back(word[j]);
			end
		end else if (pick < 80) begin
			// zero byte somewhere in or right after the prefix
			cut = $urandom_range(word.len());
			for (int j = 0; j < word.len(); j++) begin
				if (j == cut)
					q.push_back(8'd0);
				q.push_back(word[j]);
			end
			if (cut == word.len())
				q.push_back(8'd0);
			repeat ($urandom_range(3)) q.push_back(8'($urandom_range(57, 32)));
		end else if (pick < 99) begin
			// raw noise over the whole byte range, stray newlines included
			repeat ($urandom_range(10)) q.push_back(8'($urandom_range(255)));
		end else begin
			push_text(q, word);
			repeat ($urandom_range(265, 250)) q.push_back(8'($urandom_range(57, 32)));
		end
	endfunction

	// offer one byte, wait for its transaction, then queue what it must produce
	task automatic send_byte(input logic [7:0] b, input bit typed, input parse_result_t want);
		parse_result_t predicted;
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		rx_byte  <= b;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		predicted = parse_byte(b);
		pending_results.push_back(typed ? want : predicted);
		bytes_sent++;
	endtask

	task automatic send_line(ref logic [7:0] q[$]);
		foreach (q[j])
			send_byte(q[j], 1'b0, '0);
		send_byte(8'd10, 1'b0, '0);
	endtask

	// stop offering and wait until every expected result is out
	task automatic drain_results();
		in_valid <= 1'b0;
		do
			@(posedge clk);
		while (pending_results.size() != 0);
		repeat (RESULT_LATENCY + 2) @(posedge clk);
	endtask

	// write both registers while the block is idle; each write also loads the live value
	task automatic apply_settings(input logic celsius, input logic [31:0] period);
		wr_en    <= 1'b1;
		wr_index <= scl_pkg::REG_INITIAL_CELSIUS;
		wr_data  <= {31'd0, celsius};
		@(posedge clk);
		celsius_now = celsius;
		wr_index <= scl_pkg::REG_INITIAL_PERIOD;
		wr_data  <= period;
		@(posedge clk);
		period_now = period;
		wr_en <= 1'b0;
		@(posedge clk);
	endtask

	function automatic void check_field(input string name, input logic [31:0] want,
		input logic [31:0] got);
		if (want !== got) begin
			mismatch_count++;
			$display("%0t ns: %s expected %0h actual %0h", $time, name, want, got);
		end
	endfunction

	// receiver: random stalls, or a long hold-off when one is asked for
	always @(posedge clk) begin
		if (hold_request != 0) begin
			hold_left    = hold_request;
			hold_request = 0;
		end
		if (hold_left > 0) begin
			out_stall <= 1'b1;
			hold_left--;
		end else begin
			out_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	// result checker: every transaction against the oldest expectation
	always @(posedge clk) begin
		parse_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				mismatch_count++;
				$display("%0t ns: result transaction with nothing expected", $time);
			end else begin
				want = pending_results.pop_front();
				check_field("line_done",     32'(want.line_done),     32'(line_done));
				check_field("command",       32'(want.command),       32'(command));
				check_field("scale_celsius", 32'(want.scale_celsius), 32'(scale_celsius));
				check_field("stopped",       32'(want.stopped),       32'(stopped));
				check_field("report_period", want.report_period,      report_period);
				check_field("shutdown",      32'(want.shutdown),      32'(shutdown));
			end
		end
	end

	// run guard
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycle_count,
				pending_results.size());
			$display("Mismatches found");
			$finish;
		end
	end

	initial begin
		logic [7:0]    line_q [$];
		parse_result_t typed_want;
		int            sent_here;
		bit            held;
		bit            paused;

		arst_n       <= 1'b0;
		in_valid     <= 1'b0;
		rx_byte      <= 8'd0;
		wr_en        <= 1'b0;
		wr_index     <= scl_pkg::REG_INITIAL_CELSIUS;
		wr_data      <= 32'd0;
		idle_pct     = 0;
		stall_pct    = 0;
		hold_request = 0;
		hold_left    = 0;

		// predictor after reset: Fahrenheit, running, period 1
		celsius_now = 1'b0;
		halted_now  = 1'b0;
		period_now  = 32'd1;
		clear_line();

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed lines with the reset settings, light idling on both sides
		idle_pct  = 15;
		stall_pct = 15;
		foreach (directed_lines[i]) begin
			line_q.delete();
			push_text(line_q, directed_lines[i].head);
			repeat (directed_lines[i].fill_n) line_q.push_back(directed_lines[i].fill_b);
			push_text(line_q, directed_lines[i].tail);
			foreach (line_q[j])
				send_byte(line_q[j], 1'b0, '0);
			typed_want = '{1'b1, directed_lines[i].cmd, directed_lines[i].celsius,
				directed_lines[i].halted, directed_lines[i].period, directed_lines[i].off};
			send_byte(8'd10, directed_lines[i].typed, typed_want);
		end
		drain_results();

		// random lines in four idle mixes, each under its own register setting
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin
					idle_pct  = 0;
					stall_pct = 0;
					apply_settings(1'b1, 32'h7FFF_FFFF);
				end
				1: begin
					idle_pct  = 46;
					stall_pct = 0;
					apply_settings(1'b0, 32'h8000_0000);
				end
				2: begin
					idle_pct  = 0;
					stall_pct = 46;
					apply_settings(1'b1, 32'd0);
				end
				default: begin
					idle_pct  = 15;
					stall_pct = 15;
					apply_settings(1'($urandom_range(1)), $urandom);
				end
			endcase
			sent_here = 0;
			held      = 1'b0;
			paused    = 1'b0;
			while (sent_here < PHASE_BYTES) begin
				// long hold-off while bytes keep coming, so the pipe fills and stalls input
				if (ph == 0 && !held && sent_here >= 150) begin
					hold_request = HOLD_CYCLES;
					held         = 1'b1;
				end
				// sender pause until the pipe is empty
				if (ph == 1 && !paused && sent_here >= 200) begin
					drain_results();
					paused = 1'b1;
				end
				build_line(line_q);
				send_line(line_q);
				sent_here += line_q.size() + 1;
			end
			drain_results();
		end

		$display("run: %0d command bytes, %0d lines, %0d period loads, %0d off lines",
			bytes_sent, lines_seen, period_loads, off_lines);
		$display("run: four idle mixes, long receiver hold-off, five register settings");
		if (mismatch_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

FILE: files.f
hw/rtl/scl_pkg.sv
hw/rtl/scl_prefix_match.sv
hw/rtl/scl_number.sv
hw/rtl/sensor_command_line_parser_top.sv
test/testbench.sv
